[rtl/core/m256lh_pkg.sv]
// Shared constants, types and a helper function of the truncated 256-bit multiplier.
package m256lh_pkg;

    localparam int OP_BITS        = 256;
    localparam int LIMB_BITS      = 64;
    localparam int NUM_LIMBS      = 4;
    localparam int HALF_LIMB_DEF  = 32;
    localparam int MAX_DIGIT_BITS = 32;

    typedef logic [LIMB_BITS-1:0] t_limb;
    typedef logic [OP_BITS-1:0]   t_word;

    // Digits are clamped to 1..32 bits so that one digit product fits 64 bits.
    function automatic int digit_bits(input int half_bits);
        int w;
        w = half_bits;
        if (w < 1) begin
            w = 1;
        end
        if (w > MAX_DIGIT_BITS) begin
            w = MAX_DIGIT_BITS;
        end
        return w;
    endfunction

endpackage

[rtl/core/m256lh_in_if.sv]
// Operand channel: two 256-bit operands as four 64-bit limbs each.
interface m256lh_in_if;
    logic                valid;
    logic                ready;
    m256lh_pkg::t_limb   a_limb0;
    m256lh_pkg::t_limb   a_limb1;
    m256lh_pkg::t_limb   a_limb2;
    m256lh_pkg::t_limb   a_limb3;
    m256lh_pkg::t_limb   b_limb0;
    m256lh_pkg::t_limb   b_limb1;
    m256lh_pkg::t_limb   b_limb2;
    m256lh_pkg::t_limb   b_limb3;

    modport source (
        output valid, a_limb0, a_limb1, a_limb2, a_limb3,
        output b_limb0, b_limb1, b_limb2, b_limb3,
        input  ready
    );
    modport sink (
        input  valid, a_limb0, a_limb1, a_limb2, a_limb3,
        input  b_limb0, b_limb1, b_limb2, b_limb3,
        output ready
    );
endinterface

[rtl/core/m256lh_out_if.sv]
// Result channel: low 256 bits of the product as four 64-bit limbs.
interface m256lh_out_if;
    logic                valid;
    logic                ready;
    m256lh_pkg::t_limb   product_limb0;
    m256lh_pkg::t_limb   product_limb1;
    m256lh_pkg::t_limb   product_limb2;
    m256lh_pkg::t_limb   product_limb3;

    modport source (
        output valid, product_limb0, product_limb1, product_limb2, product_limb3,
        input  ready
    );
    modport sink (
        input  valid, product_limb0, product_limb1, product_limb2, product_limb3,
        output ready
    );
endinterface

[rtl/core/m256lh_pp_mul.sv]
// Partial product stage: digit products of the two operands, registered, laid out as rows.
module m256lh_pp_mul #(
    parameter int HALF_LIMB_BITS = m256lh_pkg::HALF_LIMB_DEF,
    localparam int DW    = m256lh_pkg::digit_bits(HALF_LIMB_BITS),
    localparam int NDIG  = (m256lh_pkg::OP_BITS + DW - 1) / DW,
    localparam int NP    = 2 ** $clog2(2 * NDIG)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    m256lh_in_if.sink                    i_opnd,
    output logic                         o_vld,
    input  logic                         i_rdy,
    output m256lh_pkg::t_word [NP-1:0]   o_leaf
);

    localparam int PADW = NDIG * DW;
    localparam int NTRI = NDIG * (NDIG + 1) / 2;

    typedef logic [2*DW-1:0] t_pp;

    // Position of product (i, j) in the triangle of products with i + j below NDIG.
    function automatic int tri_index(input int i, input int j);
        return i * NDIG - (i * (i - 1)) / 2 + j;
    endfunction

    logic              r_vld;
    logic              en;
    logic [PADW-1:0]   a_pad;
    logic [PADW-1:0]   b_pad;
    t_pp               r_pp [NTRI];

    assign en           = !r_vld || i_rdy;
    assign i_opnd.ready = en;
    assign o_vld        = r_vld;

    assign a_pad = PADW'({i_opnd.a_limb3, i_opnd.a_limb2, i_opnd.a_limb1, i_opnd.a_limb0});
    assign b_pad = PADW'({i_opnd.b_limb3, i_opnd.b_limb2, i_opnd.b_limb1, i_opnd.b_limb0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_opnd.valid;
        end
    end

    for (genvar gi = 0; gi < NDIG; gi++) begin : g_row
        for (genvar gj = 0; gj < NDIG - gi; gj++) begin : g_col
            localparam int T = tri_index(gi, gj);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_pp[T] <= t_pp'(a_pad[gi*DW +: DW]) * t_pp'(b_pad[gj*DW +: DW]);
                end
            end
        end
    end

    // Products of one row with even or odd column never overlap, so each row
    // spreads over two words without any addition. Bits past 256 fall away.
    always_comb begin
        o_leaf = '0;
        for (int i = 0; i < NDIG; i++) begin
            for (int j = 0; j < NDIG - i; j++) begin
                o_leaf[2*i + (j & 1)] = o_leaf[2*i + (j & 1)]
                    | (m256lh_pkg::t_word'(r_pp[tri_index(i, j)]) << ((i + j) * DW));
            end
        end
    end

endmodule

[rtl/core/m256lh_add_tree.sv]
// Registered binary adder tree that sums the partial product rows modulo 2^256.
module m256lh_add_tree #(
    parameter int HALF_LIMB_BITS = m256lh_pkg::HALF_LIMB_DEF,
    localparam int DW    = m256lh_pkg::digit_bits(HALF_LIMB_BITS),
    localparam int NDIG  = (m256lh_pkg::OP_BITS + DW - 1) / DW,
    localparam int NP    = 2 ** $clog2(2 * NDIG),
    localparam int NLVL  = $clog2(NP)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    output logic                         o_rdy,
    input  m256lh_pkg::t_word [NP-1:0]   i_leaf,
    output logic                         o_vld,
    input  logic                         i_rdy,
    output m256lh_pkg::t_word            o_sum
);

    // Heap layout: node k adds nodes 2k and 2k+1; indexes from NP upward are the leaves.
    m256lh_pkg::t_word r_node [1:NP-1];
    logic [NLVL-1:0]   r_vld;
    logic [NLVL-1:0]   en;

    // A level moves when it is empty or the level after it moves too.
    always_comb begin
        en[0] = !r_vld[0] || i_rdy;
        for (int d = 1; d < NLVL; d++) begin
            en[d] = !r_vld[d] || en[d-1];
        end
    end

    assign o_rdy = en[NLVL-1];
    assign o_vld = r_vld[0];
    assign o_sum = r_node[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[NLVL-1]) begin
                r_vld[NLVL-1] <= i_vld;
            end
            for (int d = 0; d < NLVL - 1; d++) begin
                if (en[d]) begin
                    r_vld[d] <= r_vld[d+1];
                end
            end
        end
    end

    for (genvar gk = 1; gk < NP; gk++) begin : g_node
        localparam int D = $clog2(gk + 1) - 1;
        m256lh_pkg::t_word n_node;
        if (2 * gk >= NP) begin : g_leaf_pair
            assign n_node = i_leaf[2*gk - NP] + i_leaf[2*gk + 1 - NP];
        end else begin : g_inner
            assign n_node = r_node[2*gk] + r_node[2*gk + 1];
        end
        always_ff @(posedge i_clk) begin
            if (en[D]) begin
                r_node[gk] <= n_node;
            end
        end
    end

endmodule

[rtl/core/mul256_low_half_core.sv]
// Top level of the pipelined truncated 256 x 256 bit unsigned multiplier.
//
//   Channel   Direction  Payload                               Meaning
//   i_opnd    in         a_limb0..3, b_limb0..3 (64 bits each)  operands, low limb first
//   o_prod    out        product_limb0..3 (64 bits each)        (a * b) mod 2^256
//
// One item can be accepted in every cycle while the output takes results. An item
// passes through the digit multiplier registers and then one register per level of the
// adder tree, whose leaf count NP is twice the digit count rounded up to a power of two.
// Reset clears only the valid bits of the stages. Each stage moves when it is
// empty or the stage after it moves, so bubbles close up during a stall and a finished
// result waiting at the output stops new items from entering only once every stage
// holds an item.
module mul256_low_half_core #(
    parameter int HALF_LIMB_BITS = m256lh_pkg::HALF_LIMB_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    m256lh_in_if.sink     i_opnd,
    m256lh_out_if.source  o_prod
);

    localparam int DW   = m256lh_pkg::digit_bits(HALF_LIMB_BITS);
    localparam int NDIG = (m256lh_pkg::OP_BITS + DW - 1) / DW;
    localparam int NP   = 2 ** $clog2(2 * NDIG);
    localparam int LB   = m256lh_pkg::LIMB_BITS;

    logic                        pp_vld;
    logic                        tree_rdy;
    m256lh_pkg::t_word [NP-1:0]  pp_leaf;
    m256lh_pkg::t_word           sum;

    // First stage: every digit product whose weight lies below 2^256, one multiplier each.
    m256lh_pp_mul #(
        .HALF_LIMB_BITS (HALF_LIMB_BITS)
    ) u_pp_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_opnd  (i_opnd),
        .o_vld   (pp_vld),
        .i_rdy   (tree_rdy),
        .o_leaf  (pp_leaf)
    );

    // Remaining stages: one 256-bit add per node, one register level per tree level.
    // The root register is the output register of the block.
    m256lh_add_tree #(
        .HALF_LIMB_BITS (HALF_LIMB_BITS)
    ) u_add_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (pp_vld),
        .o_rdy   (tree_rdy),
        .i_leaf  (pp_leaf),
        .o_vld   (o_prod.valid),
        .i_rdy   (o_prod.ready),
        .o_sum   (sum)
    );

    assign o_prod.product_limb0 = sum[0*LB +: LB];
    assign o_prod.product_limb1 = sum[1*LB +: LB];
    assign o_prod.product_limb2 = sum[2*LB +: LB];
    assign o_prod.product_limb3 = sum[3*LB +: LB];

endmodule
